[rtl/core/oaht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package oaht_pkg;

    // Number of slots. A power of two, so the home slot is the low bits of the hash.
    localparam int CAPACITY = 256;

    // Slot state codes held in the slot-state memory.
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    // Request opcodes.
    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_LOAD = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    localparam int KEY_W   = 32;
    localparam int HASH_W  = 32;
    localparam int VALUE_W = 64;
    localparam int CNT_W   = 9;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/core/open_addressing_hash_table.sv]
// Requests are handled one at a time: a new request is taken only once the result of the last
// has gone to the output register; a result held back by the receiver delays the next.
// A no-operation request skips the probe; the probe loop reads one slot per cycle, stopping at
// a hit, at an empty slot or after the whole table.
// Reset: synchronous, active low. After reset a clearing pass marks every slot empty;
// no request is accepted until it ends, while configuration writes are taken.
`timescale 1ns / 1ps
`default_nettype none

module open_addressing_hash_table
    import oaht_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    // Configuration: max_load_entries.
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [8:0]   i_cfg_data,

    // Request channel.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // key_id [31:0], key_hash [63:32], set_value [127:64]
    input  wire logic [1:0]   s_axis_tuser,   // opcode [1:0]

    // Result channel.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // read_value [63:0]
    output logic [2:0]        m_axis_tuser    // found [0], status [2:1]
);

    localparam int  IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int  CW      = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] LAST_CNT  = CW'(CAPACITY - 1);

    // Slot memories: state is cleared by the pass after reset, key and value are only
    // read from live slots and need no clearing.
    logic [1:0]                 st_mem [CAPACITY];
    logic [KEY_W+VALUE_W-1:0]   kv_mem [CAPACITY];

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_max_load;
    logic [CNT_W-1:0]   r_used_cnt;
    logic [CNT_W-1:0]   r_live_cnt;

    // Request being worked on.
    logic [1:0]         r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_val;

    // Probe walk.
    logic [IW-1:0]      r_addr;
    logic [IW-1:0]      r_daddr;
    logic               r_dv;
    logic [CW-1:0]      r_cnt;
    logic               r_tomb_v;
    logic [IW-1:0]      r_tomb_at;
    logic [IW-1:0]      r_clr;

    // Slot read data, registered: it arrives in the cycle after the address.
    logic [1:0]                 st_q;
    logic [KEY_W+VALUE_W-1:0]   kv_q;

    // Pending result and output register.
    logic               r_res_found;
    logic [VALUE_W-1:0] r_res_rv;
    logic [1:0]         r_res_status;
    logic               r_m_valid;
    logic               r_m_found;
    logic [VALUE_W-1:0] r_m_rv;
    logic [1:0]         r_m_status;

    // Decoded request payload.
    logic [KEY_W-1:0]   in_key;
    logic [HASH_W-1:0]  in_hash;
    logic [VALUE_W-1:0] in_val;
    logic               in_fire;

    assign in_key  = s_axis_tdata[31:0];
    assign in_hash = s_axis_tdata[63:32];
    assign in_val  = s_axis_tdata[127:64];
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Evaluation of the slot whose data has just arrived.
    logic          slot_hit;
    logic          slot_tomb;
    logic          slot_empty;
    logic          probe_last;
    logic          probe_stop;
    logic          tomb_any;
    logic [IW-1:0] tomb_at;
    logic          load_ok;
    logic          out_free;

    assign slot_hit   = (st_q == SLOT_LIVE) && (kv_q[KEY_W-1:0] == r_key);
    assign slot_tomb  = (st_q == SLOT_TOMB);
    assign slot_empty = (st_q != SLOT_LIVE) && (st_q != SLOT_TOMB);
    assign probe_last = (r_cnt == LAST_CNT);
    assign probe_stop = r_dv && (slot_hit || slot_empty || probe_last);
    assign tomb_any   = r_tomb_v || slot_tomb;
    assign tomb_at    = r_tomb_v ? r_tomb_at : r_daddr;
    assign load_ok    = ({1'b0, r_used_cnt} + 10'd1) <= {1'b0, r_max_load};
    assign out_free   = !r_m_valid || m_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser == OP_NOP) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (probe_stop) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory writes, count updates and the result of a finished probe.
    logic                     st_we;
    logic [IW-1:0]            st_waddr;
    logic [1:0]               st_wdata;
    logic                     kv_we;
    logic [IW-1:0]            kv_waddr;
    logic                     used_inc;
    logic                     live_inc;
    logic                     live_dec;
    logic                     res_found;
    logic [VALUE_W-1:0]       res_rv;
    logic [1:0]               res_status;

    always_comb begin
        st_we      = 1'b0;
        st_waddr   = r_daddr;
        st_wdata   = SLOT_LIVE;
        kv_we      = 1'b0;
        kv_waddr   = r_daddr;
        used_inc   = 1'b0;
        live_inc   = 1'b0;
        live_dec   = 1'b0;
        res_found  = 1'b0;
        res_rv     = '0;
        res_status = STAT_OK;
        s_axis_tready = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
                st_wdata = SLOT_EMPTY;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_PROBE: begin
                if (probe_stop) begin
                    unique case (r_op)
                        OP_GET: begin
                            res_found = slot_hit;
                            res_rv    = slot_hit ? kv_q[KEY_W+VALUE_W-1:KEY_W] : '0;
                        end
                        OP_SET: begin
                            if (slot_hit) begin
                                res_found = 1'b1;
                                kv_we     = 1'b1;
                            end else if (tomb_any) begin
                                // Reuse the first tombstone passed on the way.
                                st_we    = 1'b1;
                                st_waddr = tomb_at;
                                kv_we    = 1'b1;
                                kv_waddr = tomb_at;
                                live_inc = 1'b1;
                            end else if (slot_empty) begin
                                if (load_ok) begin
                                    st_we    = 1'b1;
                                    kv_we    = 1'b1;
                                    used_inc = 1'b1;
                                    live_inc = 1'b1;
                                end else begin
                                    res_status = STAT_LOAD;
                                end
                            end else begin
                                res_status = STAT_FULL;
                            end
                        end
                        OP_DEL: begin
                            if (slot_hit) begin
                                res_found = 1'b1;
                                st_we     = 1'b1;
                                st_wdata  = SLOT_TOMB;
                                live_dec  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Slot memories: one write port each, registered read at the probe address.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_q <= st_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            kv_mem[kv_waddr] <= {r_val, r_key};
        end
        kv_q <= kv_mem[r_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_dv       <= 1'b0;
            r_tomb_v   <= 1'b0;
            r_used_cnt <= '0;
            r_live_cnt <= '0;
            r_max_load <= 9'd192;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_max_load <= i_cfg_data;
            end

            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            if (used_inc) begin
                r_used_cnt <= r_used_cnt + 1'b1;
            end
            if (live_inc) begin
                r_live_cnt <= r_live_cnt + 1'b1;
            end else if (live_dec) begin
                r_live_cnt <= r_live_cnt - 1'b1;
            end

            if (in_fire) begin
                r_dv     <= 1'b0;
                r_tomb_v <= 1'b0;
            end else if (r_state == S_PROBE) begin
                r_dv <= !probe_stop;
                if (r_dv && slot_tomb && !r_tomb_v) begin
                    r_tomb_v <= 1'b1;
                end
            end

            if (r_state == S_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op     <= s_axis_tuser;
            r_key    <= in_key;
            r_val    <= in_val;
            r_cnt    <= '0;
            r_addr   <= in_hash[IW-1:0];
            r_res_found  <= 1'b0;
            r_res_rv     <= '0;
            r_res_status <= STAT_OK;
        end else if (r_state == S_PROBE) begin
            // Issue the next slot while the previous one is evaluated.
            r_addr  <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
            r_daddr <= r_addr;
            if (r_dv) begin
                r_cnt <= r_cnt + 1'b1;
                if (slot_tomb && !r_tomb_v) begin
                    r_tomb_at <= r_daddr;
                end
            end
            if (probe_stop) begin
                r_res_found  <= res_found;
                r_res_rv     <= res_rv;
                r_res_status <= res_status;
            end
        end

        if (r_state == S_DONE && out_free) begin
            r_m_found  <= r_res_found;
            r_m_rv     <= r_res_rv;
            r_m_status <= r_res_status;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_rv;
    assign m_axis_tuser  = {r_m_status, r_m_found};

    // After a request is taken, tready is low in the following cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    // Live slots are a subset of used slots.
    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live_cnt <= r_used_cnt)
        else $error("live count exceeds used count");

    // A refused insert never reports a present key.
    a_refuse_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:1] != STAT_OK) |-> !m_axis_tuser[0])
        else $error("refusal reported together with found");

    // No request is accepted before the clearing pass has finished.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

endmodule

`default_nettype wire

[verif/oaht_checker.sv]
`timescale 1ns / 1ps

module oaht_checker
    import oaht_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    input  wire logic         i_cfg_valid,
    input  wire logic         o_cfg_ready,
    input  wire logic [8:0]   i_cfg_data,

    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // key_id [31:0], key_hash [63:32], set_value [127:64]
    input  wire logic [1:0]   s_axis_tuser,   // opcode [1:0]

    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [63:0]  m_axis_tdata,   // read_value [63:0]
    input  wire logic [2:0]   m_axis_tuser,   // found [0], status [2:1]

    output int                o_fail_count,
    output int                o_pending
);

    localparam int BUCKETS = CAPACITY;
    localparam logic [CNT_W-1:0] LOAD_AFTER_RESET = 9'd192;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } t_lookup_result;

    logic [1:0]         bucket_mark  [BUCKETS];
    logic [KEY_W-1:0]   bucket_key   [BUCKETS];
    logic [VALUE_W-1:0] bucket_value [BUCKETS];
    logic [CNT_W-1:0]   occupied_cnt;
    logic [CNT_W-1:0]   live_cnt;
    logic [CNT_W-1:0]   load_limit;
    t_lookup_result     results_due [$];
    t_lookup_result     want;
    t_lookup_result     got;
    t_lookup_result     fresh;
    int                 fail_total;
    int                 b;

    // Walks the probe chain for one request, applies its effect on the table
    // copy and returns the result the block owes for it.
    task automatic resolve_lookup(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                  input logic [HASH_W-1:0] hash,
                                  input logic [VALUE_W-1:0] val,
                                  output t_lookup_result res);
        int idx;
        int n;
        int hit_at;
        int tomb_at;
        int hole_at;
        bit hit;
        bit tomb;
        bit hole;
        res = '0;
        hit = 1'b0;
        tomb = 1'b0;
        hole = 1'b0;
        hit_at = 0;
        tomb_at = 0;
        hole_at = 0;
        idx = int'(hash % 32'(BUCKETS));
        for (n = 0; n < BUCKETS && !hit && !hole; n++) begin
            if (bucket_mark[idx] == SLOT_LIVE) begin
                if (bucket_key[idx] == key) begin
                    hit = 1'b1;
                    hit_at = idx;
                end
            end else if (bucket_mark[idx] == SLOT_TOMB) begin
                if (!tomb) begin
                    tomb = 1'b1;
                    tomb_at = idx;
                end
            end else begin
                hole = 1'b1;
                hole_at = idx;
            end
            idx = (idx + 1) % BUCKETS;
        end

        case (op)
            OP_GET: begin
                if (hit) begin
                    res.found = 1'b1;
                    res.value = bucket_value[hit_at];
                end
            end
            OP_SET: begin
                if (hit) begin
                    res.found = 1'b1;
                    bucket_value[hit_at] = val;
                end else if (tomb) begin
                    // A reused tombstone is already counted as used.
                    bucket_mark[tomb_at] = SLOT_LIVE;
                    bucket_key[tomb_at] = key;
                    bucket_value[tomb_at] = val;
                    live_cnt = live_cnt + 1'b1;
                end else if (hole) begin
                    if ({1'b0, occupied_cnt} + 10'd1 > {1'b0, load_limit}) begin
                        res.status = STAT_LOAD;
                    end else begin
                        bucket_mark[hole_at] = SLOT_LIVE;
                        bucket_key[hole_at] = key;
                        bucket_value[hole_at] = val;
                        occupied_cnt = occupied_cnt + 1'b1;
                        live_cnt = live_cnt + 1'b1;
                    end
                end else begin
                    res.status = STAT_FULL;
                end
            end
            OP_DEL: begin
                if (hit) begin
                    res.found = 1'b1;
                    bucket_mark[hit_at] = SLOT_TOMB;
                    live_cnt = live_cnt - 1'b1;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (b = 0; b < BUCKETS; b++) begin
                bucket_mark[b] = SLOT_EMPTY;
            end
            occupied_cnt = '0;
            live_cnt = '0;
            load_limit = LOAD_AFTER_RESET;
            results_due.delete();
            fail_total = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.found = m_axis_tuser[0];
                got.status = m_axis_tuser[2:1];
                got.value = m_axis_tdata;
                if (results_due.size() == 0) begin
                    $error("unrequested result: found %0d read_value %h status %0d",
                           got.found, got.value, got.status);
                    fail_total++;
                end else begin
                    want = results_due.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        fail_total++;
                    end
                    if (got.value !== want.value) begin
                        $error("read_value: expected %h, got %h", want.value, got.value);
                        fail_total++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_total++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                load_limit = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                resolve_lookup(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                               s_axis_tdata[127:64], fresh);
                results_due.push_back(fresh);
            end
        end
        o_fail_count <= fail_total;
        o_pending <= results_due.size();
    end

endmodule

[verif/open_addressing_hash_table_tb.sv]
`timescale 1ns / 1ps

module open_addressing_hash_table_tb;
    import oaht_pkg::*;

    // The run is bounded by a watchdog well above the slowest legal run:
    // every request walking all 256 slots, with full idle gaps on both sides.
    localparam int RUN_LIMIT_NS     = 4_000_000;
    localparam int DRAIN_LIMIT      = 20_000;
    localparam int TAIL_CYCLES      = 300;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int POOL_MAX         = 64;
    localparam int FILL_ITEMS       = 300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [8:0]         i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [127:0]       s_axis_tdata = '0;   // key_id [31:0], key_hash [63:32], set_value [127:64]
    logic [1:0]         s_axis_tuser = '0;   // opcode [1:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [63:0]        m_axis_tdata;        // read_value [63:0]
    logic [2:0]         m_axis_tuser;        // found [0], status [2:1]

    int                 fail_count;
    int                 pending;
    bit                 no_sender_gaps = 1'b0;
    logic [KEY_W-1:0]   pool_key  [POOL_MAX];
    logic [HASH_W-1:0]  pool_hash [POOL_MAX];
    logic [KEY_W-1:0]   fill_key  [FILL_ITEMS];
    logic [HASH_W-1:0]  fill_hash [FILL_ITEMS];

    open_addressing_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // The checker sits beside the block, sees every handshake on all three
    // channels and reports back how many checks failed and how many results
    // are still owed.
    oaht_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Offers one request. The valid line is only dropped when an idle gap is
    // drawn, so back-to-back requests keep it high without a glitch. The task
    // returns in the time step of the handshake.
    task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                input logic [HASH_W-1:0] hash,
                                input logic [VALUE_W-1:0] val);
        int gap;
        gap = no_sender_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, hash, key};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stops offering and waits until every result owed has come back. The
    // pending count from the checker is registered, so the loop steps the
    // clock before it first trusts the count.
    task automatic wait_until_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
    endtask

    // Writes the load limit. Only called while no request is in flight.
    task automatic write_load_limit(input logic [8:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // A random phase works on a small pool of keys so that gets, deletes and
    // repeated sets actually hit. A clustered pool puts every home slot
    // within a dozen buckets, which builds long probe chains and tombstone
    // runs; a spread pool hashes anywhere. A few requests are pure noise.
    task automatic run_mixed_phase(input int items, input int pool_size,
                                   input bit clustered, input bit gapless);
        int n;
        int pick;
        int r;
        logic [7:0] home_base;
        logic [HASH_W-1:0] h;
        logic [VALUE_W-1:0] v;
        home_base = 8'($urandom_range(0, 255));
        for (n = 0; n < pool_size; n++) begin
            pool_key[n] = $urandom;
            h = $urandom;
            if (clustered) begin
                h[7:0] = home_base + 8'($urandom_range(0, 11));
            end
            pool_hash[n] = h;
        end
        no_sender_gaps = gapless;
        for (n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            pick = $urandom_range(0, pool_size - 1);
            if (r % 16 == 0) begin
                v = '1;
            end else if (r % 16 == 1) begin
                v = '0;
            end else begin
                v = {$urandom, $urandom};
            end
            if (r < 4) begin
                send_request(2'($urandom_range(0, 3)), $urandom, $urandom, v);
            end else if (r < 45) begin
                send_request(OP_SET, pool_key[pick], pool_hash[pick], v);
            end else if (r < 78) begin
                send_request(OP_GET, pool_key[pick], pool_hash[pick], v);
            end else if (r < 96) begin
                send_request(OP_DEL, pool_key[pick], pool_hash[pick], v);
            end else begin
                send_request(OP_NOP, pool_key[pick], pool_hash[pick], v);
            end
        end
        no_sender_gaps = 1'b0;
    endtask

    // The result side stalls a random number of cycles before each result.
    // Around the 150th result it holds off for a long stretch while the
    // sender keeps going, so the block backs up and stalls its request
    // channel. A later window of results is taken with no stalls at all.
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken == 150) begin
                gap = LONG_HOLD_CYCLES;
            end else if (taken >= 400 && taken < 550) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 7);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : stimulus
        int n;
        int idx;
        int r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A tight limit of four used slots, so the load refusal shows up
        // within the directed requests. This write lands during the
        // clearing pass, which the block allows.
        write_load_limit(9'd4);

        // Directed part. The first keys all home to slot 0.
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000, '1);            // empty table
        send_request(OP_SET, 32'h0000_0000, 32'h0000_0000, '1);            // new key
        send_request(OP_SET, 32'h0000_0000, 32'h0000_0000, '0);            // overwrite
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000, '1);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'h0000_0100, 64'h0123_4567_89AB_CDEF);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0100, '0);            // one hop
        send_request(OP_DEL, 32'h0000_0000, 32'h0000_0000, '0);            // leaves tombstone
        send_request(OP_DEL, 32'h0000_0000, 32'h0000_0000, '0);            // already gone
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0100, '0);            // skips tombstone
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000, '0);            // miss past tombstone
        send_request(OP_SET, 32'h0000_0005, 32'hFFFF_FF00, 64'hFEDC_BA98_7654_3210);
        send_request(OP_SET, 32'h0000_0006, 32'hFFFF_FFFF, 64'h5555_5555_AAAA_AAAA);
        send_request(OP_SET, 32'h0000_0007, 32'h0000_01FF, 64'hAAAA_AAAA_5555_5555); // wraps
        send_request(OP_SET, 32'h0000_0008, 32'h0000_0010, 64'h1);         // over the limit
        send_request(OP_GET, 32'h0000_0007, 32'h0000_01FF, '0);            // wrapped chain
        send_request(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        send_request(OP_NOP, 32'h0000_0000, 32'h0000_0000, '0);
        wait_until_drained();

        // A limit of zero refuses every insert into an empty slot, yet
        // tombstone reuse and overwrites still succeed.
        write_load_limit(9'd0);
        send_request(OP_SET, 32'h0000_0009, 32'h0000_0020, 64'h2);         // refused
        send_request(OP_DEL, 32'h0000_0006, 32'hFFFF_FFFF, '0);            // tombstone at 255
        send_request(OP_SET, 32'h0000_0009, 32'h0000_00FF, 64'h3);         // reuses it
        send_request(OP_SET, 32'h0000_0005, 32'hFFFF_FF00, 64'h4);         // overwrite
        send_request(OP_DEL, 32'h1234_5678, 32'h0000_0040, '0);            // absent key
        wait_until_drained();

        // Random phases, each at its own load limit. The table is never
        // cleared, so tombstones pile up from phase to phase.
        write_load_limit(9'd40);
        run_mixed_phase(220, 32, 1'b1, 1'b0);
        wait_until_drained();

        write_load_limit(9'd1);
        run_mixed_phase(150, 24, 1'b0, 1'b1);
        wait_until_drained();

        write_load_limit(9'($urandom_range(100, 255)));
        run_mixed_phase(220, 48, 1'b0, 1'b0);
        wait_until_drained();

        write_load_limit(9'd192);
        run_mixed_phase(200, 40, 1'b1, 1'b0);
        wait_until_drained();

        // With the limit at full capacity, a stream of distinct new keys
        // takes every empty slot and every tombstone. Once all slots are
        // live, further inserts find no place at all and every miss walks
        // the whole table.
        write_load_limit(9'd256);
        for (n = 0; n < FILL_ITEMS; n++) begin
            fill_key[n] = 32'hA500_0000 | 32'(n);
            fill_hash[n] = $urandom;
            send_request(OP_SET, fill_key[n], fill_hash[n], {$urandom, $urandom});
        end
        for (n = 0; n < 60; n++) begin
            idx = $urandom_range(0, FILL_ITEMS - 1);
            r = $urandom_range(0, 2);
            case (r)
                0: begin
                    send_request(OP_GET, fill_key[idx], fill_hash[idx], '0);
                end
                1: begin
                    send_request(OP_DEL, fill_key[idx], fill_hash[idx], '0);
                end
                default: begin
                    send_request(OP_SET, 32'hB600_0000 | 32'(n), $urandom,
                                 {$urandom, $urandom});
                end
            endcase
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[open_addressing_hash_table.f]
rtl/core/oaht_pkg.sv
rtl/core/open_addressing_hash_table.sv
verif/oaht_checker.sv
verif/open_addressing_hash_table_tb.sv
